/* src/fhm31_pkg.sv */
// Shared types and constants for the binary64 hash modulo 2^31-1 pipeline.
package fhm31_pkg;

    localparam int HASH_BITS = 31;
    localparam logic [30:0] HASH_MODULUS = 31'h7FFF_FFFF;
    localparam logic signed [31:0] HASH_INF = 32'sd314159;
    localparam logic [10:0] EXPO_SPECIAL = 11'h7FF;
    // The unbiased exponent of the lowest significand bit is expo - 1075,
    // and -1075 is congruent to 10 modulo 31.
    localparam logic [11:0] ROT_OFFSET = 12'd10;

    typedef enum logic [1:0] {
        CLS_FINITE,
        CLS_INF,
        CLS_NAN
    } value_class_t;

    typedef struct packed {
        value_class_t cls;
        logic         negative;
        logic [31:0]  mant_fold;
        logic [6:0]   rot_fold;
    } unpack_t;

    typedef struct packed {
        value_class_t cls;
        logic         negative;
        logic [30:0]  residue;
        logic [4:0]   rot;
    } reduce_t;

    typedef struct packed {
        value_class_t cls;
        logic         negative;
        logic [30:0]  rotated;
    } rotate_t;

endpackage

/* src/fhm31_unpack.sv */
// First stage: field split, classification and first folds of significand and exponent.
module fhm31_unpack (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [63:0]        value_bits,
    output logic               out_valid,
    input  logic               out_ready,
    output fhm31_pkg::unpack_t out_data
);

    logic               valid_reg;
    logic               valid_next;
    fhm31_pkg::unpack_t data_reg;
    fhm31_pkg::unpack_t data_next;

    logic [10:0] expo;
    logic [51:0] frac;
    logic [52:0] mant;
    logic [11:0] rot_base;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        expo = value_bits[62:52];
        frac = value_bits[51:0];
        if (expo == 11'd0)
        begin
            // Subnormals share the exponent of the smallest normal.
            mant     = {1'b0, frac};
            rot_base = 12'd1 + fhm31_pkg::ROT_OFFSET;
        end
        else
        begin
            mant     = {1'b1, frac};
            rot_base = {1'b0, expo} + fhm31_pkg::ROT_OFFSET;
        end
        data_next.negative  = value_bits[63];
        data_next.mant_fold = {1'b0, mant[30:0]} + {10'd0, mant[52:31]};
        data_next.rot_fold  = {2'b00, rot_base[4:0]} + {2'b00, rot_base[9:5]}
                            + {5'd0, rot_base[11:10]};
        if (expo == fhm31_pkg::EXPO_SPECIAL)
        begin
            data_next.cls = (frac != 52'd0) ? fhm31_pkg::CLS_NAN : fhm31_pkg::CLS_INF;
        end
        else
        begin
            data_next.cls = fhm31_pkg::CLS_FINITE;
        end
    end

    always_comb
    begin
        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

/* src/fhm31_reduce.sv */
// Second stage: final reduction of the significand residue and the rotate amount.
module fhm31_reduce (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  fhm31_pkg::unpack_t in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output fhm31_pkg::reduce_t out_data
);

    logic               valid_reg;
    logic               valid_next;
    fhm31_pkg::reduce_t data_reg;
    fhm31_pkg::reduce_t data_next;

    logic [31:0] mant_sum;
    logic [5:0]  rot_sum;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        mant_sum = {1'b0, in_data.mant_fold[30:0]} + {31'd0, in_data.mant_fold[31]};
        if (mant_sum >= {1'b0, fhm31_pkg::HASH_MODULUS})
        begin
            mant_sum = mant_sum - {1'b0, fhm31_pkg::HASH_MODULUS};
        end
        rot_sum = {1'b0, in_data.rot_fold[4:0]} + {4'd0, in_data.rot_fold[6:5]};
        if (rot_sum >= 6'd31)
        begin
            rot_sum = rot_sum - 6'd31;
        end
        data_next.cls      = in_data.cls;
        data_next.negative = in_data.negative;
        data_next.residue  = mant_sum[30:0];
        data_next.rot      = rot_sum[4:0];
    end

    always_comb
    begin
        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

`ifndef SYNTHESIS
    a_residue_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (data_reg.residue != fhm31_pkg::HASH_MODULUS))
        else $error("Residue left unreduced.");
    a_rot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (data_reg.rot < 5'd31))
        else $error("Rotate amount out of range.");
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !out_ready) |=> (valid_reg && $stable(data_reg)))
        else $error("Stalled item changed or dropped.");
`endif

endmodule

/* src/fhm31_finish.sv */
// Last two stages: rotation of the residue, then sign and special-value selection.
module fhm31_finish (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  fhm31_pkg::reduce_t in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] hash_value
);

    logic               rot_valid_reg;
    logic               rot_valid_next;
    fhm31_pkg::rotate_t rot_reg;
    fhm31_pkg::rotate_t rot_next;
    logic               rot_ready;

    logic               res_valid_reg;
    logic               res_valid_next;
    logic signed [31:0] res_reg;
    logic signed [31:0] res_next;

    logic [61:0] doubled;

    assign rot_ready = !res_valid_reg || out_ready;
    assign in_ready  = !rot_valid_reg || rot_ready;

    always_comb
    begin
        doubled           = {in_data.residue, in_data.residue} << in_data.rot;
        rot_next.cls      = in_data.cls;
        rot_next.negative = in_data.negative;
        rot_next.rotated  = doubled[61:31];
    end

    always_comb
    begin
        case (rot_reg.cls)
            fhm31_pkg::CLS_FINITE:
            begin
                res_next = rot_reg.negative ? -$signed({1'b0, rot_reg.rotated})
                                            : $signed({1'b0, rot_reg.rotated});
            end
            fhm31_pkg::CLS_INF:
            begin
                res_next = rot_reg.negative ? -fhm31_pkg::HASH_INF : fhm31_pkg::HASH_INF;
            end
            default:
            begin
                res_next = 32'sd0;
            end
        endcase
    end

    always_comb
    begin
        rot_valid_next = in_ready ? in_valid : rot_valid_reg;
        res_valid_next = rot_ready ? rot_valid_reg : res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            rot_valid_reg <= rot_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            rot_reg <= rot_next;
        end
        if (rot_valid_reg && rot_ready)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid  = res_valid_reg;
    assign hash_value = res_reg;

endmodule

/* src/float_hash_mod_mersenne31_top.sv */
// Top level of the binary64 hash modulo 2^31-1 pipeline.
//
// Each item is one binary64 bit pattern and yields one signed 32-bit hash: the
// value modulo 2^31-1 with the input's sign, 314159 or -314159 for the
// infinities, and 0 for zeros and NaN. The pipeline has four register stages
// (unpack and first fold, final reduction, rotation, sign and special-value
// selection), and one item can be accepted in every cycle while the output
// is not stalled. Each stage advances when the stage after it is empty or
// moving, so a stall at the output fills the pipeline without losing or
// repeating an item.
module float_hash_mod_mersenne31_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [63:0]        value_bits,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] hash_value
);

    logic               unpack_valid;
    logic               unpack_ready;
    fhm31_pkg::unpack_t unpack_data;
    logic               reduce_valid;
    logic               reduce_ready;
    fhm31_pkg::reduce_t reduce_data;

    fhm31_unpack u_unpack (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .value_bits (value_bits),
        .out_valid  (unpack_valid),
        .out_ready  (unpack_ready),
        .out_data   (unpack_data)
    );

    fhm31_reduce u_reduce (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (unpack_valid),
        .in_ready  (unpack_ready),
        .in_data   (unpack_data),
        .out_valid (reduce_valid),
        .out_ready (reduce_ready),
        .out_data  (reduce_data)
    );

    fhm31_finish u_finish (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (reduce_valid),
        .in_ready   (reduce_ready),
        .in_data    (reduce_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .hash_value (hash_value)
    );

endmodule

/* dv/float_hash_mod_mersenne31_top_test.sv */
// Testbench for the binary64 hash modulo 2^31-1 pipeline with a self-checking scoreboard.
module float_hash_mod_mersenne31_top_test;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 342;
    localparam int DRAIN_CYCLES = 8;

    class hash_scoreboard;
        logic signed [31:0] expected_hashes[$];
        int mismatches;
        int hashes_checked;
        int items_noted;

        function logic signed [31:0] predict_hash(logic [63:0] bits);
            logic        sign;
            logic [10:0] expo;
            logic [51:0] frac;
            logic [63:0] mant;
            logic [63:0] residue;
            logic [31:0] hash;
            int          expo_int;
            int          lsb_expo;
            int          rot;
            sign = bits[63];
            expo = bits[62:52];
            frac = bits[51:0];
            if (expo == fhm31_pkg::EXPO_SPECIAL)
            begin
                if (frac != 0)
                    return 32'sd0;
                return sign ? -fhm31_pkg::HASH_INF : fhm31_pkg::HASH_INF;
            end
            expo_int = expo;
            if (expo == 11'd0)
            begin
                mant = {12'd0, frac};
                lsb_expo = -1074;
            end
            else
            begin
                mant = {11'd0, 1'b1, frac};
                lsb_expo = expo_int - 1075;
            end
            residue = mant % 64'(fhm31_pkg::HASH_MODULUS);
            rot = lsb_expo % fhm31_pkg::HASH_BITS;
            if (rot < 0)
                rot += fhm31_pkg::HASH_BITS;
            residue = (residue << rot) % 64'(fhm31_pkg::HASH_MODULUS);
            hash = residue[31:0];
            if (sign)
                hash = -hash;
            return hash;
        endfunction

        function void note_value(logic [63:0] bits);
            expected_hashes.push_back(predict_hash(bits));
            items_noted++;
        endfunction

        task report_mismatch(string what);
            $display("MISMATCH at %0t: %s", $realtime, what);
            mismatches++;
        endtask

        task check_hash(logic signed [31:0] got);
            logic signed [31:0] want;
            if (expected_hashes.size() == 0)
            begin
                report_mismatch($sformatf("hash %0d arrived with no item pending", got));
                return;
            end
            want = expected_hashes.pop_front();
            hashes_checked++;
            if (got !== want)
                report_mismatch($sformatf("hash_value got %0d expected %0d", got, want));
        endtask
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [63:0]        value_bits;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] hash_value;

    int send_idle_pct;
    int recv_idle_pct;
    int cycle_count;

    hash_scoreboard sb = new();

    float_hash_mod_mersenne31_top u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .value_bits (value_bits),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .hash_value (hash_value)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles.", cycle_count);
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_hash(hash_value);
            if (in_valid && in_ready)
                sb.note_value(value_bits);
        end
    end

    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function logic [63:0] random_value();
        logic [63:0] raw;
        logic [10:0] expo;
        raw = {$urandom, $urandom};
        case ($urandom_range(7))
            0, 1: return raw;
            2: return {raw[63], 11'd0, raw[51:0]};
            3: return {raw[63], 11'h7FF, ($urandom_range(1) == 0) ? 52'd0 : raw[51:0]};
            4:
            begin
                expo = 11'(1023 + $urandom_range(80) - 40);
                return {raw[63], expo, raw[51:0]};
            end
            5: return {raw[63:52], 52'd0};
            6:
            begin
                expo = 11'($urandom_range(2046, 1));
                return {raw[63], expo, raw[51:0]};
            end
            default: return {raw[63], 11'($urandom_range(30) + 1040), raw[51:0]};
        endcase
    endfunction

    task send_value(input logic [63:0] bits);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        value_bits <= bits;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    initial
    begin
        logic [63:0] corner_values [20] = '{
            64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000,
            64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000,
            64'h7FF8_0000_0000_0000, 64'h7FF0_0000_0000_0001,
            64'hFFFF_FFFF_FFFF_FFFF, 64'h7FEF_FFFF_FFFF_FFFF,
            64'hFFEF_FFFF_FFFF_FFFF, 64'h0010_0000_0000_0000,
            64'h0000_0000_0000_0001, 64'h8000_0000_0000_0001,
            64'h000F_FFFF_FFFF_FFFF, 64'h3FF0_0000_0000_0000,
            64'hBFF0_0000_0000_0000, 64'h4000_0000_0000_0000,
            64'h3FE0_0000_0000_0000, 64'h41DF_FFFF_FFC0_0000,
            64'h4330_0000_0000_0000, 64'h5555_5555_5555_5555
        };
        rst_n = 1'b0;
        in_valid = 1'b0;
        value_bits = 64'd0;
        send_idle_pct = 30;
        recv_idle_pct = 75;
        cycle_count = 0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (corner_values[i])
            send_value(corner_values[i]);

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 30 : (phase == 1) ? 75 : 0;
            recv_idle_pct = (phase == 0) ? 75 : (phase == 1) ? 30 : 0;
            repeat (PHASE_ITEMS)
                send_value(random_value());
        end
        in_valid <= 1'b0;

        while (sb.expected_hashes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Hashed %0d items, %0d results checked: signed zeros, infinities, NaNs,",
                 sb.items_noted, sb.hashes_checked);
        $display("subnormals and random doubles under three flow-control mixes.");
        if (sb.mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
